// ===== design/ism_pkg.sv =====
// ----------------------------------------------------------------------------
// ism_pkg
// shared types and constants for the interval sort and merge block
// ----------------------------------------------------------------------------
package ism_pkg;

	localparam int unsigned POS_W         = 32;
	localparam int unsigned MAX_INTERVALS = 64;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_SORT,
		ST_LOAD,
		ST_MERGE,
		ST_EMIT
	} ism_state_t;

	// controller to datapath
	typedef struct packed {
		logic store_in;   // write accepted word into the store
		logic sort_step;  // run one odd/even transposition pass
		logic load_first; // load first sorted entry as current interval
		logic merge_step; // fold current store entry into the merged interval
		logic open_next;  // current entry opens a new merged interval
		logic emit;       // present the merged interval on the output
		logic clear;      // clear fill count, overflow mark and merge index
	} ism_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sort_done;  // pass counter reached the entry count
		logic last_entry; // merge index is on the final stored entry
		logic hit;        // current entry overlaps the merged interval
	} ism_sts_t;

endpackage

// ===== design/ism_ctrl.sv =====
// ----------------------------------------------------------------------------
// ism_ctrl
// sequencer for fill, sort, load, merge and emit phases
// ----------------------------------------------------------------------------
module ism_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_last,
	input  logic              out_fire,
	input  ism_pkg::ism_sts_t sts,
	output ism_pkg::ism_cmd_t cmd,
	output logic              in_ready,
	output logic              out_valid,
	output logic              out_final
);

	ism_pkg::ism_state_t state_q, state_d;
	logic                final_q, final_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ism_pkg::ST_FILL;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		final_d = final_q;
		case (state_q)
			ism_pkg::ST_FILL: begin
				if (in_fire && in_last) state_d = ism_pkg::ST_SORT;
			end
			ism_pkg::ST_SORT: begin
				if (sts.sort_done) state_d = ism_pkg::ST_LOAD;
			end
			ism_pkg::ST_LOAD: begin
				if (sts.last_entry) begin
					state_d = ism_pkg::ST_EMIT;
					final_d = 1'b1;
				end else begin
					state_d = ism_pkg::ST_MERGE;
				end
			end
			ism_pkg::ST_MERGE: begin
				if (!sts.hit) begin
					state_d = ism_pkg::ST_EMIT;
					final_d = 1'b0;
				end else if (sts.last_entry) begin
					state_d = ism_pkg::ST_EMIT;
					final_d = 1'b1;
				end
			end
			ism_pkg::ST_EMIT: begin
				if (out_fire) begin
					if (final_q) state_d = ism_pkg::ST_FILL;
					else if (sts.last_entry) begin
						state_d = ism_pkg::ST_EMIT;
						final_d = 1'b1;
					end else state_d = ism_pkg::ST_MERGE;
				end
			end
			default: state_d = ism_pkg::ST_FILL;
		endcase
	end

	// outputs
	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		out_final  = final_q;
		case (state_q)
			ism_pkg::ST_FILL: begin
				in_ready     = 1'b1;
				cmd.store_in = in_fire;
			end
			ism_pkg::ST_SORT:  cmd.sort_step  = 1'b1;
			ism_pkg::ST_LOAD:  cmd.load_first = 1'b1;
			ism_pkg::ST_MERGE: cmd.merge_step = sts.hit;
			ism_pkg::ST_EMIT: begin
				out_valid     = 1'b1;
				cmd.emit      = 1'b1;
				cmd.open_next = out_fire && !final_q;
				cmd.clear     = out_fire && final_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/ism_dp.sv =====
// ----------------------------------------------------------------------------
// ism_dp
// interval store with odd/even transposition sort and merge registers
// ----------------------------------------------------------------------------
module ism_dp #(
	parameter int unsigned MAX_N = ism_pkg::MAX_INTERVALS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ism_pkg::ism_cmd_t         cmd,
	input  logic                      merge_touching,
	input  logic [ism_pkg::POS_W-1:0] in_start,
	input  logic [ism_pkg::POS_W-1:0] in_stop,
	output ism_pkg::ism_sts_t         sts,
	output logic [ism_pkg::POS_W-1:0] out_start,
	output logic [ism_pkg::POS_W-1:0] out_stop,
	output logic                      out_dropped
);

	localparam int unsigned CW = $clog2(MAX_N + 1);
	localparam int unsigned IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int unsigned EW = 2 * ism_pkg::POS_W;

	// entries form a row of cells, each compared only with its neighbor
	logic [EW-1:0]  cell_q [MAX_N];
	logic [CW-1:0]  fill_q;
	logic           ovf_q;
	logic [CW-1:0]  pass_q;
	logic [IW-1:0]  idx_q;
	logic [ism_pkg::POS_W-1:0] cur_s_q, cur_e_q;
	logic [EW-1:0]  nxt [MAX_N];
	logic [ism_pkg::POS_W-1:0] ent_s, ent_e;

	// one transposition pass, parity from the pass counter
	always_comb begin
		for (int i = 0; i < MAX_N; i++) nxt[i] = cell_q[i];
		for (int i = 0; i + 1 < MAX_N; i++) begin
			if ((i[0] == pass_q[0]) && (CW'(i + 1) < fill_q) &&
			    (cell_q[i] > cell_q[i+1])) begin
				nxt[i]   = cell_q[i+1];
				nxt[i+1] = cell_q[i];
			end
		end
	end

	// store and sort cells, then shift the sorted row toward cell 0 while merging
	always_ff @(posedge clk) begin
		if (cmd.store_in && (fill_q < CW'(MAX_N)))
			cell_q[fill_q[IW-1:0]] <= {in_start, in_stop};
		else if (cmd.sort_step)
			for (int i = 0; i < MAX_N; i++) cell_q[i] <= nxt[i];
		else if (cmd.load_first || cmd.merge_step || cmd.open_next)
			for (int i = 0; i + 1 < MAX_N; i++) cell_q[i] <= cell_q[i+1];
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			pass_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.store_in) begin
				if (fill_q < CW'(MAX_N)) fill_q <= fill_q + 1'b1;
				else                     ovf_q  <= 1'b1;
			end
			if (cmd.sort_step) pass_q <= pass_q + 1'b1;
			else               pass_q <= '0;
			if (cmd.load_first) idx_q <= IW'(1);
			else if (cmd.merge_step || cmd.open_next) idx_q <= idx_q + 1'b1;
			if (cmd.clear) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
				idx_q  <= '0;
			end
		end
	end

	// next entry to fold in always sits in cell 0
	assign ent_s = cell_q[0][EW-1:ism_pkg::POS_W];
	assign ent_e = cell_q[0][ism_pkg::POS_W-1:0];

	// current merged interval
	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			cur_s_q <= cell_q[0][EW-1:ism_pkg::POS_W];
			cur_e_q <= cell_q[0][ism_pkg::POS_W-1:0];
		end else if (cmd.merge_step) begin
			if (ent_e > cur_e_q) cur_e_q <= ent_e;
		end else if (cmd.open_next) begin
			cur_s_q <= ent_s;
			cur_e_q <= ent_e;
		end
	end

	// status
	always_comb begin
		sts.sort_done  = (pass_q >= fill_q);
		sts.last_entry = (CW'(idx_q) >= CW'(fill_q - 1'b1)) || (fill_q <= CW'(1));
		sts.hit        = (merge_touching ? (ent_s <= cur_e_q) : (ent_s < cur_e_q))
		                 && (ent_e >= cur_s_q);
	end

	assign out_start   = cur_s_q;
	assign out_stop    = cur_e_q;
	assign out_dropped = ovf_q;

endmodule

// ===== design/interval_sort_merge_top.sv =====
// ----------------------------------------------------------------------------
// interval_sort_merge_top
// sorts a set of intervals by start then stop, and merges overlaps
// ----------------------------------------------------------------------------
// usage
// - s_axis word: start_pos, stop_pos in tdata; tlast marks the final interval
// - a word with tlast starts sort and merge; no input is taken until the
//   last merged interval of the set has been taken on m_axis
// - m_axis word: merged_start, merged_stop in tdata; tlast marks the final
//   merged interval, tuser carries the dropped flag for the set
// - intervals beyond MAX_INTERVALS are discarded and the set is flagged
// - fill stores the words in turn; sort: n + 1 passes of the odd/even cell row,
//   one per cycle; a load step; merge: each stored interval after the first
//   is folded in, and a new interval opens after each result
// - a stalled m_axis holds the word; the sequencer waits in place
// - reset empties the store and clears merge_touching
// ----------------------------------------------------------------------------
module interval_sort_merge_top #(
	parameter int unsigned MAX_INTERVALS = ism_pkg::MAX_INTERVALS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // start_pos[31:0], stop_pos[63:32]
	input  logic        s_axis_tlast,   // last_item
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // merged_start[31:0], merged_stop[63:32]
	output logic        m_axis_tlast,   // final_result
	output logic        m_axis_tuser    // dropped_flag
);

	ism_pkg::ism_cmd_t cmd;
	ism_pkg::ism_sts_t sts;
	logic              touch_q;
	logic              in_fire, out_fire;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     touch_q <= 1'b0;
		else if (cfg_we) touch_q <= cfg_wdata;
	end

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	ism_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_last   (s_axis_tlast),
		.out_fire  (out_fire),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_final (m_axis_tlast)
	);

	ism_dp #(.MAX_N(MAX_INTERVALS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.merge_touching (touch_q),
		.in_start       (s_axis_tdata[31:0]),
		.in_stop        (s_axis_tdata[63:32]),
		.sts            (sts),
		.out_start      (m_axis_tdata[31:0]),
		.out_stop       (m_axis_tdata[63:32]),
		.out_dropped    (m_axis_tuser)
	);

	// no input taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input and output both open");

	// taking the final merged word returns to fill
	a_final_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && m_axis_tlast) |=> s_axis_tready) else $error("no return to fill");

	// a last input word closes the fill phase
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tlast) |=> !s_axis_tready) else $error("fill not closed");

endmodule
